// ----- design/word_break_matcher_defines.svh -----
// assertion macros for the word break matcher
`ifndef WORD_BREAK_MATCHER_DEFINES_SVH
`define WORD_BREAK_MATCHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("word_break_matcher same-cycle check failed");

// next-cycle implication, checked outside reset
`define WBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("word_break_matcher next-cycle check failed");

`endif

// ----- design/wbm_pkg.sv -----
// shared types and constants for the word break matcher
`timescale 1ns / 1ps

package wbm_pkg;

    localparam int DICT_WORDS_DEF = 64;
    localparam int MAX_WORD_DEF   = 16;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_WORD  = 2'd1,
        K_TEXT  = 2'd2,
        K_EMPTY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_LONG = 2'd2;

    localparam logic ANS_WORD = 1'b0;
    localparam logic ANS_TEXT = 1'b1;

endpackage

// ----- design/word_break_matcher.sv -----
// word break matcher top level: sequencer, word loader, text history
`timescale 1ns / 1ps

// Decides whether a streamed text splits wholly into dictionary words.
// Control words (clear, dictionary characters, empty text) start no scan.
// A text character keeps the block busy from its acceptance to the next
// ready cycle: the dictionary memory hands one stored word per cycle to a
// single compare unit that checks it against the newest text characters,
// then the last compare drains and the history updates.
// A word or text answer then waits in the output register until taken.
// The input side is held off whenever an answer waits and the receiver is
// not taking it, and the last character of a text holds in its final cycle
// until the previous answer has gone.
// Words are stored newest character first, so no alignment shift is needed.
// No clearing pass runs after reset; only committed rows are ever read.

`include "word_break_matcher_defines.svh"

module word_break_matcher #(
    parameter int DICT_WORDS = wbm_pkg::DICT_WORDS_DEF,
    parameter int MAX_WORD   = wbm_pkg::MAX_WORD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_code,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_answer_kind,
    output logic       o_breakable,
    output logic [1:0] o_error
);

    import wbm_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int CNT_W = $clog2(DICT_WORDS + 1);
    localparam int IDX_W = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
    localparam int ROW_W = LEN_W + MAX_WORD * 8;

    t_state r_state, n_state;

    logic [CNT_W-1:0]         r_count;
    logic [LEN_W-1:0]         r_load_len;
    logic                     r_too_long;
    logic [MAX_WORD-1:0][7:0] r_load_buf;
    logic [MAX_WORD-1:0][7:0] r_window;
    logic [MAX_WORD:0]        r_hist;
    logic                     r_started;
    logic [CNT_W-1:0]         r_issue;
    logic                     r_rd_vld;
    logic                     r_now;
    logic                     r_last;
    logic                     r_ov;
    logic                     r_ans_kind;
    logic                     r_brk;
    logic [1:0]               r_err;

    logic [MAX_WORD-1:0][7:0] n_load_buf;
    logic [MAX_WORD-1:0][7:0] n_window;
    logic [LEN_W-1:0]         n_load_len;

    t_kind            kind;
    logic             in_fire;
    logic             out_free;
    logic             rd_en;
    logic             fin_fire;
    logic             load_fits;
    logic             too_long_now;
    logic [1:0]       word_err;
    logic             word_fire;
    logic             word_end;
    logic             commit;
    logic [ROW_W-1:0] rd_row;
    logic             match;

    assign kind     = t_kind'(i_kind);
    assign out_free = !r_ov || i_out_ready;
    assign in_fire  = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && kind == K_TEXT) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!rd_en && !r_rd_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (fin_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        fin_fire   = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = out_free;
            S_SCAN:   rd_en      = (r_issue < r_count);
            S_FINISH: fin_fire   = !r_last || out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // word loader: characters shift in at entry 0, newest first
    always_comb begin
        for (int k = MAX_WORD - 1; k > 0; k--) begin
            n_load_buf[k] = r_load_buf[k - 1];
        end
        n_load_buf[0] = i_char_code;
    end

    assign load_fits    = (r_load_len < LEN_W'(MAX_WORD));
    assign n_load_len   = r_load_len + 1'b1;
    assign too_long_now = r_too_long || !load_fits;
    assign word_fire    = in_fire && (kind == K_WORD);
    assign word_end     = word_fire && i_last;

    always_comb begin
        if (too_long_now) begin
            word_err = ERR_LONG;
        end else if (r_count >= CNT_W'(DICT_WORDS)) begin
            word_err = ERR_FULL;
        end else begin
            word_err = ERR_NONE;
        end
    end

    assign commit = word_end && (word_err == ERR_NONE);

    // text window for a new character; a fresh text starts from zeros
    always_comb begin
        for (int k = MAX_WORD - 1; k > 0; k--) begin
            n_window[k] = r_started ? r_window[k - 1] : 8'd0;
        end
        n_window[0] = i_char_code;
    end

    wbm_dict_mem #(
        .DEPTH (DICT_WORDS),
        .WIDTH (ROW_W),
        .IDX_W (IDX_W)
    ) u_dict_mem (
        .i_clk     (i_clk),
        .i_wr_en   (commit),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({n_load_len, n_load_buf}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_row)
    );

    wbm_match_unit #(
        .MAX_WORD (MAX_WORD),
        .LEN_W    (LEN_W)
    ) u_match_unit (
        .i_row_len   (rd_row[ROW_W-1 -: LEN_W]),
        .i_row_chars (rd_row[MAX_WORD*8-1:0]),
        .i_window    (r_window),
        .i_history   (r_hist),
        .o_match     (match)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_load_len <= '0;
            r_too_long <= 1'b0;
            r_hist     <= (MAX_WORD + 1)'(1);
            r_started  <= 1'b0;
            r_issue    <= '0;
            r_rd_vld   <= 1'b0;
            r_now      <= 1'b0;
            r_last     <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            if (in_fire) begin
                case (kind)
                    K_CLEAR: begin
                        r_count    <= '0;
                        r_load_len <= '0;
                        r_too_long <= 1'b0;
                    end
                    K_WORD: begin
                        if (i_last) begin
                            r_load_len <= '0;
                            r_too_long <= 1'b0;
                            r_ov       <= 1'b1;
                        end else if (load_fits) begin
                            r_load_len <= n_load_len;
                        end else begin
                            r_too_long <= 1'b1;
                        end
                        if (commit) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    K_TEXT: begin
                        if (!r_started) begin
                            r_hist <= (MAX_WORD + 1)'(1);
                        end
                        r_started <= 1'b1;
                        r_issue   <= '0;
                        r_now     <= 1'b0;
                        r_last    <= i_last;
                    end
                    K_EMPTY: begin
                        r_started <= 1'b0;
                        r_ov      <= 1'b1;
                    end
                    default: begin
                        r_started <= r_started;
                    end
                endcase
            end

            if (rd_en) begin
                r_issue <= r_issue + 1'b1;
            end
            if (r_rd_vld && match) begin
                r_now <= 1'b1;
            end

            if (fin_fire) begin
                r_hist <= {r_hist[MAX_WORD-1:0], r_now};
                if (r_last) begin
                    r_started <= 1'b0;
                    r_ov      <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (word_fire && load_fits) begin
            r_load_buf <= n_load_buf;
        end
        if (in_fire && kind == K_TEXT) begin
            r_window <= n_window;
        end
        if (word_end) begin
            r_ans_kind <= ANS_WORD;
            r_brk      <= 1'b0;
            r_err      <= word_err;
        end else if (in_fire && kind == K_EMPTY) begin
            r_ans_kind <= ANS_TEXT;
            r_brk      <= 1'b0;
            r_err      <= ERR_NONE;
        end else if (fin_fire && r_last) begin
            r_ans_kind <= ANS_TEXT;
            r_brk      <= r_now;
            r_err      <= ERR_NONE;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_answer_kind = r_ans_kind;
    assign o_breakable   = r_brk;
    assign o_error       = r_err;

    `WBM_ASSERT_NOW(a_busy_not_ready, r_state != S_IDLE, !o_in_ready)
    `WBM_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= CNT_W'(DICT_WORDS))
    `WBM_ASSERT_NOW(a_text_no_error, o_out_valid && o_answer_kind == ANS_TEXT,
                    o_error == ERR_NONE)
    `WBM_ASSERT_NEXT(a_read_only_in_scan, rd_en, r_rd_vld && r_state != S_IDLE)

endmodule

// ----- design/wbm_dict_mem.sv -----
// dictionary row memory: one write port, one registered read port
`timescale 1ns / 1ps

module wbm_dict_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 133,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/wbm_match_unit.sv -----
// shared compare unit: one stored word against the text window
`timescale 1ns / 1ps

module wbm_match_unit #(
    parameter int MAX_WORD = 16,
    parameter int LEN_W    = $clog2(MAX_WORD + 1)
) (
    input  logic [LEN_W-1:0]         i_row_len,
    input  logic [MAX_WORD-1:0][7:0] i_row_chars,
    input  logic [MAX_WORD-1:0][7:0] i_window,
    input  logic [MAX_WORD:0]        i_history,
    output logic                     o_match
);

    logic [MAX_WORD-1:0] hit;
    logic                gate;

    // rows are stored newest-first, so position j lines up with window entry j
    always_comb begin
        for (int j = 0; j < MAX_WORD; j++) begin
            hit[j] = (LEN_W'(j) >= i_row_len) || (i_row_chars[j] == i_window[j]);
        end
    end

    // prefix in front of the word must itself be breakable
    assign gate    = (i_row_len != '0) ? i_history[i_row_len - 1'b1] : 1'b0;
    assign o_match = gate && (&hit);

endmodule
